[rtl/ssfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_pkg
// Shared types and constants of the two-wire segment display frame sender.
// ----------------------------------------------------------------------------
package ssfs_pkg;

    // item kinds carried in tuser
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_START = 2'd2
    } t_op;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS  = 1'b1;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [2:0] DIGIT_COUNT_RST = 3'd4;
    localparam logic [2:0] BRIGHTNESS_RST  = 3'd7;

    // command bytes
    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_ADDR_0    = 8'hC0;
    localparam logic [7:0] CMD_DISP_ON   = 8'h88;

    // frame sequence: start = two steps, byte bit = three steps, stop = four steps
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_STA1_A = 5'd1,  PH_STA1_B = 5'd2,
        PH_CMD_0  = 5'd3,  PH_CMD_1  = 5'd4,  PH_CMD_2  = 5'd5,
        PH_STP1_0 = 5'd6,  PH_STP1_1 = 5'd7,  PH_STP1_2 = 5'd8,  PH_STP1_3 = 5'd9,
        PH_STA2_A = 5'd10, PH_STA2_B = 5'd11,
        PH_ADR_0  = 5'd12, PH_ADR_1  = 5'd13, PH_ADR_2  = 5'd14,
        PH_DIG_0  = 5'd15, PH_DIG_1  = 5'd16, PH_DIG_2  = 5'd17,
        PH_STP2_0 = 5'd18, PH_STP2_1 = 5'd19, PH_STP2_2 = 5'd20, PH_STP2_3 = 5'd21,
        PH_STA3_A = 5'd22, PH_STA3_B = 5'd23,
        PH_CTL_0  = 5'd24, PH_CTL_1  = 5'd25, PH_CTL_2  = 5'd26,
        PH_STP3_0 = 5'd27, PH_STP3_1 = 5'd28, PH_STP3_2 = 5'd29, PH_STP3_3 = 5'd30
    } t_phase;

    // line levels after one item
    typedef struct packed {
        logic busy;
        logic dio;
        logic clk;
    } t_lines;

endpackage

[rtl/ssfs_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssfs_step
// Frame sequencer: segment store, config registers, phase/bit/byte counters
// and line registers. Applies one item per strobe and shows the next levels.
// ----------------------------------------------------------------------------
module ssfs_step #(
    parameter int unsigned MAX_DIGITS       = 6,
    parameter int unsigned START_STOP_TICKS = 5,
    parameter int unsigned BIT_PHASE_TICKS  = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ssfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ssfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_item_vld,
    input  ssfs_pkg::t_op                     i_op,
    input  logic [2:0]                        i_digit_index,
    input  logic [7:0]                        i_segment_byte,
    output ssfs_pkg::t_lines                  o_next
);

    localparam int unsigned IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [7:0]           r_store [MAX_DIGITS];
    ssfs_pkg::t_phase     r_phase, n_phase;
    logic [2:0]           r_byte, n_byte;
    logic [2:0]           r_bit, n_bit;
    logic [2:0]           r_wait, n_wait;
    logic                 r_clk, n_clk;
    logic                 r_dio, n_dio;
    logic [2:0]           r_digit_count;
    logic [2:0]           r_brightness;

    logic                 busy;
    logic [3:0]           eff_digits;
    logic [2:0]           wait_dec;
    logic                 go;
    ssfs_pkg::t_phase     tgt;
    logic                 store_we;
    logic [7:0]           tx_byte;
    logic [7:0]           dig_byte;

    assign busy = (r_phase != ssfs_pkg::PH_IDLE);
    assign eff_digits = ({1'b0, r_digit_count} > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS)
                                                                  : {1'b0, r_digit_count};
    assign wait_dec = (r_wait != 3'd0) ? r_wait - 3'd1 : 3'd0;
    assign store_we = i_item_vld && (i_op == ssfs_pkg::OP_LOAD) && !busy
                      && ({1'b0, i_digit_index} < 4'(MAX_DIGITS));

    always_comb begin
        n_phase = r_phase;
        n_byte  = r_byte;
        n_bit   = r_bit;
        n_wait  = r_wait;
        n_clk   = r_clk;
        n_dio   = r_dio;
        go      = 1'b0;
        tgt     = ssfs_pkg::PH_IDLE;

        if (i_item_vld) begin
            case (i_op)
                ssfs_pkg::OP_TICK: begin
                    if (busy) begin
                        n_wait = wait_dec;
                        if (wait_dec == 3'd0) begin
                            go = 1'b1;
                            case (r_phase)
                                ssfs_pkg::PH_CMD_2, ssfs_pkg::PH_ADR_2,
                                ssfs_pkg::PH_DIG_2, ssfs_pkg::PH_CTL_2: begin
                                    if (r_bit != 3'd7) begin
                                        n_bit = r_bit + 3'd1;
                                        tgt   = ssfs_pkg::t_phase'(r_phase - 5'd2);
                                    end else begin
                                        n_bit = 3'd0;
                                        case (r_phase)
                                            ssfs_pkg::PH_CMD_2: tgt = ssfs_pkg::PH_STP1_0;
                                            ssfs_pkg::PH_ADR_2: begin
                                                n_byte = 3'd0;
                                                tgt = (eff_digits == 4'd0) ? ssfs_pkg::PH_STP2_0
                                                                           : ssfs_pkg::PH_DIG_0;
                                            end
                                            ssfs_pkg::PH_DIG_2: begin
                                                if (({1'b0, r_byte} + 4'd1) < eff_digits) begin
                                                    n_byte = r_byte + 3'd1;
                                                    tgt    = ssfs_pkg::PH_DIG_0;
                                                end else begin
                                                    tgt    = ssfs_pkg::PH_STP2_0;
                                                end
                                            end
                                            default: tgt = ssfs_pkg::PH_STP3_0;
                                        endcase
                                    end
                                end
                                ssfs_pkg::PH_STP3_3: tgt = ssfs_pkg::PH_IDLE;
                                default: tgt = ssfs_pkg::t_phase'(r_phase + 5'd1);
                            endcase
                        end
                    end
                end
                ssfs_pkg::OP_START: begin
                    if (!busy) begin
                        n_byte = 3'd0;
                        n_bit  = 3'd0;
                        tgt    = ssfs_pkg::PH_STA1_A;
                        go     = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // segment byte of the digit being sent
        dig_byte = ({1'b0, n_byte} < 4'(MAX_DIGITS)) ? r_store[n_byte[IDX_W-1:0]] : 8'd0;

        // byte whose bit goes out on a data-set step
        case (tgt)
            ssfs_pkg::PH_CMD_1: tx_byte = ssfs_pkg::CMD_DATA_AUTO;
            ssfs_pkg::PH_ADR_1: tx_byte = ssfs_pkg::CMD_ADDR_0;
            ssfs_pkg::PH_CTL_1: tx_byte = ssfs_pkg::CMD_DISP_ON | {5'd0, r_brightness};
            default:            tx_byte = dig_byte;
        endcase

        // line action of the phase being entered
        if (go) begin
            n_phase = tgt;
            case (tgt) inside
                ssfs_pkg::PH_IDLE: n_wait = 3'd0;
                ssfs_pkg::PH_STA1_A, ssfs_pkg::PH_STA2_A, ssfs_pkg::PH_STA3_A: begin
                    n_dio  = 1'b1;
                    n_clk  = 1'b1;
                    n_wait = 3'(START_STOP_TICKS);
                end
                ssfs_pkg::PH_STA1_B, ssfs_pkg::PH_STA2_B, ssfs_pkg::PH_STA3_B: begin
                    n_dio  = 1'b0;
                    n_wait = 3'(START_STOP_TICKS);
                end
                ssfs_pkg::PH_CMD_0, ssfs_pkg::PH_ADR_0, ssfs_pkg::PH_DIG_0,
                ssfs_pkg::PH_CTL_0: begin
                    n_clk  = 1'b0;
                    n_wait = 3'(BIT_PHASE_TICKS);
                end
                ssfs_pkg::PH_CMD_1, ssfs_pkg::PH_ADR_1, ssfs_pkg::PH_DIG_1,
                ssfs_pkg::PH_CTL_1: begin
                    n_dio  = tx_byte[n_bit];
                    n_wait = 3'(BIT_PHASE_TICKS);
                end
                ssfs_pkg::PH_CMD_2, ssfs_pkg::PH_ADR_2, ssfs_pkg::PH_DIG_2,
                ssfs_pkg::PH_CTL_2: begin
                    n_clk  = 1'b1;
                    n_wait = 3'(BIT_PHASE_TICKS);
                end
                ssfs_pkg::PH_STP1_0, ssfs_pkg::PH_STP2_0, ssfs_pkg::PH_STP3_0: begin
                    n_clk  = 1'b0;
                    n_wait = 3'(START_STOP_TICKS);
                end
                ssfs_pkg::PH_STP1_1, ssfs_pkg::PH_STP2_1, ssfs_pkg::PH_STP3_1: begin
                    n_dio  = 1'b0;
                    n_wait = 3'(START_STOP_TICKS);
                end
                ssfs_pkg::PH_STP1_2, ssfs_pkg::PH_STP2_2, ssfs_pkg::PH_STP3_2: begin
                    n_clk  = 1'b1;
                    n_wait = 3'(START_STOP_TICKS);
                end
                default: begin
                    n_dio  = 1'b1;
                    n_wait = 3'(START_STOP_TICKS);
                end
            endcase
        end
    end

    assign o_next.clk  = n_clk;
    assign o_next.dio  = n_dio;
    assign o_next.busy = (n_phase != ssfs_pkg::PH_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= ssfs_pkg::PH_IDLE;
            r_byte        <= 3'd0;
            r_bit         <= 3'd0;
            r_wait        <= 3'd0;
            r_clk         <= 1'b1;
            r_dio         <= 1'b1;
            r_digit_count <= ssfs_pkg::DIGIT_COUNT_RST;
            r_brightness  <= ssfs_pkg::BRIGHTNESS_RST;
        end else begin
            if (i_item_vld) begin
                r_phase <= n_phase;
                r_byte  <= n_byte;
                r_bit   <= n_bit;
                r_wait  <= n_wait;
                r_clk   <= n_clk;
                r_dio   <= n_dio;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ssfs_pkg::CFG_DIGIT_COUNT: r_digit_count <= i_cfg_data;
                    ssfs_pkg::CFG_BRIGHTNESS:  r_brightness  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // segment store: contents undefined until loaded
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[i_digit_index[IDX_W-1:0]] <= i_segment_byte;
        end
    end

endmodule

[rtl/seven_segment_serial_frame_sender.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_serial_frame_sender
// Two-wire seven-segment display link driver, one item per clock while the master side accepts.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the op (tick, load segment byte, start frame),
//   tdata the digit index and segment byte used by a load. Every accepted beat
//   yields exactly one master beat with the clock line, data line and busy
//   levels as they stand after that item.
//   Config port: i_cfg_we/i_cfg_idx/i_cfg_data write digit count (index 0) or
//   brightness (index 1); write them only while no beat is in flight. A write
//   during a frame applies to the bytes that follow.
//   Path: a beat is registered on accept in the input register, applied to
//   the sequencer once the output register is free, and its result registered
//   in the output register, which drives o_m_axis_tvalid. Throughput is one
//   beat per cycle while i_m_axis_tready stays high; the sequencer computes
//   the next levels combinationally between the input and output registers.
//   Stall: if the master side holds tready low, the output register holds its
//   beat and the input register takes one more beat, then tready drops.
//   Reset (synchronous, active low): lines high, idle, digit count 4,
//   brightness 7; the segment store is not cleared and must be loaded first.
// ----------------------------------------------------------------------------
module seven_segment_serial_frame_sender #(
    parameter int unsigned MAX_DIGITS       = 6,
    parameter int unsigned START_STOP_TICKS = 5,
    parameter int unsigned BIT_PHASE_TICKS  = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ssfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ssfs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [15:0]                       i_s_axis_tdata,  // digit_index[2:0], segment_byte[10:3]
    input  logic [1:0]                        i_s_axis_tuser,  // op[1:0]
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata   // clk_level[0], dio_level[1], busy_res[2]
);

    logic               r_in_vld;
    ssfs_pkg::t_op      r_in_op;
    logic [2:0]         r_in_idx;
    logic [7:0]         r_in_seg;
    logic               r_out_vld;
    ssfs_pkg::t_lines   r_out;
    ssfs_pkg::t_lines   next_lines;
    logic               apply;

    assign apply           = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || apply;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (apply) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_op  <= ssfs_pkg::t_op'(i_s_axis_tuser);
            r_in_idx <= i_s_axis_tdata[2:0];
            r_in_seg <= i_s_axis_tdata[10:3];
        end
        if (apply) begin
            r_out <= next_lines;
        end
    end

    ssfs_step #(
        .MAX_DIGITS       (MAX_DIGITS),
        .START_STOP_TICKS (START_STOP_TICKS),
        .BIT_PHASE_TICKS  (BIT_PHASE_TICKS)
    ) u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_item_vld     (apply),
        .i_op           (r_in_op),
        .i_digit_index  (r_in_idx),
        .i_segment_byte (r_in_seg),
        .o_next         (next_lines)
    );

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'd0, r_out.busy, r_out.dio, r_out.clk};

endmodule
